@@ hdl/assert_macros.svh @@
// assertion macros shared by the chain unit rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FLC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define FLC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FLC_ASSERT(lbl, prop, msg)
`define FLC_ASSERT_IMP(lbl, ante, cons, msg)
`define FLC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/flc_pkg.sv @@
// types, constants and helper functions of the segment chain unit
// no dependencies
`default_nettype none
package flc_pkg;
	localparam int SEGMENTS     = 8;
	localparam int SEG_W        = $clog2(SEGMENTS);
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int ITERS        = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int IT_W         = $clog2(TAB_LEN);
	localparam int CW           = 40;
	localparam int VEC_SHIFT    = 20;
	localparam int FRAC_SHIFT   = 24;
	localparam int SW           = CW + 2;
	localparam logic [23:0] KINV_FIX = 24'd10188014;
	localparam logic [15:0] HEAD_PI  = 16'h8000;

	localparam logic [1:0] REG_HEAD = 2'd0;
	localparam logic [1:0] REG_BODY = 2'd1;
	localparam logic [1:0] REG_TAIL = 2'd2;

	typedef struct packed {
		logic              op;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
	} tgt_t;

	typedef struct packed {
		logic [2:0]         segment_index;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [15:0]        heading;
		logic               moved;
		logic               last;
	} seg_t;

	// stored state of one segment
	typedef struct packed {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic [15:0]        hd;
	} segst_t;

	function automatic logic [31:0] atan_turn(input logic [IT_W-1:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) r = 16'sh7FFF;
		else if (v < -24'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

@@ hdl/flc_cell.sv @@
// one link of the segment chain: holds a segment, takes its neighbor's on shift
// uses flc_pkg
`default_nettype none
module flc_cell import flc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire segst_t d,
	output segst_t      q
);
	segst_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (shift) begin
			seg_q <= d;
		end
	end

	assign q = seg_q;
endmodule
`default_nettype wire

@@ hdl/flc_cordic.sv @@
// iterative cordic: vectoring for the heading (skipped for a zero vector), then rotation for the offset
// uses flc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module flc_cordic import flc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [16:0] dx,
	input  wire logic signed [16:0] dy,
	input  wire logic [7:0]         len,
	output logic                    done,
	output logic [15:0]             heading,
	output logic signed [CW-1:0]    ox,
	output logic signed [CW-1:0]    oy
);
	localparam logic [2:0] C_IDLE  = 3'd0;
	localparam logic [2:0] C_VEC   = 3'd1;
	localparam logic [2:0] C_RINIT = 3'd2;
	localparam logic [2:0] C_ROT   = 3'd3;
	localparam logic [2:0] C_DONE  = 3'd4;
	localparam logic [IT_W-1:0] I_LAST = IT_W'(ITERS - 1);

	logic [2:0]              st_q;
	logic [IT_W-1:0]         i_q;
	logic signed [CW-1:0]    x_q, y_q;
	logic [31:0]             z_q;
	logic signed [33:0]      a_q;
	logic [15:0]             hd_q;
	logic [7:0]              len_q;

	logic signed [CW-1:0]    xs, ys, vx, vy, rx;
	logic [31:0]             at, zn, zr;
	logic signed [33:0]      a0;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = atan_turn(i_q);
		zn = (y_q > 0) ? z_q + at : z_q - at;
		zr = zn + 32'h80008000;
		vx = {{(CW-17-VEC_SHIFT){dx[16]}}, dx, {VEC_SHIFT{1'b0}}};
		vy = {{(CW-17-VEC_SHIFT){dy[16]}}, dy, {VEC_SHIFT{1'b0}}};
		rx = $signed(CW'(len_q * KINV_FIX));
		a0 = {{2{hd_q[15]}}, hd_q, 16'h0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			i_q  <= '0;
		end else begin
			case (st_q)
				C_IDLE: begin
					if (start) begin
						len_q <= len;
						i_q   <= '0;
						if (dx == 17'sd0 && dy == 17'sd0) begin
							hd_q <= HEAD_PI;
							st_q <= C_RINIT;
						end else begin
							// fold left half plane onto the right
							if (vx < 0) begin
								x_q <= -vx;
								y_q <= -vy;
								z_q <= 32'h80000000;
							end else begin
								x_q <= vx;
								y_q <= vy;
								z_q <= 32'h0;
							end
							st_q <= C_VEC;
						end
					end
				end
				C_VEC: begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
					end
					z_q <= zn;
					i_q <= i_q + 1'b1;
					if (i_q == I_LAST) begin
						hd_q <= zr[31:16];
						st_q <= C_RINIT;
					end
				end
				C_RINIT: begin
					i_q <= '0;
					y_q <= '0;
					if (a0 > 34'sh040000000) begin
						a_q <= a0 - 34'sh080000000;
						x_q <= -rx;
					end else if (a0 < -34'sh040000000) begin
						a_q <= a0 + 34'sh080000000;
						x_q <= -rx;
					end else begin
						a_q <= a0;
						x_q <= rx;
					end
					st_q <= C_ROT;
				end
				C_ROT: begin
					if (a_q >= 0) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						a_q <= a_q - $signed({2'b00, at});
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						a_q <= a_q + $signed({2'b00, at});
					end
					i_q <= i_q + 1'b1;
					if (i_q == I_LAST) begin
						st_q <= C_DONE;
					end
				end
				C_DONE: begin
					st_q <= C_IDLE;
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

	assign done    = (st_q == C_DONE);
	assign heading = hd_q;
	assign ox      = x_q;
	assign oy      = y_q;

	`FLC_ASSERT_IMP(a_iter_range, st_q == C_VEC || st_q == C_ROT, i_q <= I_LAST, "cordic step out of range")
	`FLC_ASSERT_NXT(a_done_pulse, st_q == C_DONE, st_q == C_IDLE, "done held too long")
	`FLC_ASSERT_NXT(a_vec_to_rot, st_q == C_VEC && i_q == I_LAST, st_q == C_RINIT, "vectoring did not hand over")
endmodule
`default_nettype wire

@@ hdl/follow_leader_segment_chain_unit.sv @@
// top level of the follow-the-leader segment chain: control, config, cell row
// uses flc_pkg, flc_cell, flc_cordic and assert_macros.svh
//
// channel  dir  handshake              beat
// tgt      in   tgt_valid/tgt_ready    one target point with op
// seg      out  seg_valid/seg_ready    one segment result, SEGMENTS per target
// cfg      in   cfg_we                 one length register write
//
// a follow that moves runs the shared cordic (vectoring then rotation) once
// per segment; place and unmoved follow skip the cordic and go from load
// straight to emit
// segments sit in a row of cells and rotate past the front once per target
// a stalled seg beat holds the current segment; tgt_ready is low while busy
// reset clears all segments to zero and loads the default lengths
`default_nettype none
`include "assert_macros.svh"
module follow_leader_segment_chain_unit import flc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tgt_valid,
	output logic            tgt_ready,
	input  wire tgt_t       tgt,
	output logic            seg_valid,
	input  wire logic       seg_ready,
	output seg_t            seg,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_CALC = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

	logic [2:0]         st_q;
	logic [SEG_W-1:0]   idx_q;
	logic               op_q, moved_q;
	logic signed [15:0] lx_q, ly_q;
	logic [7:0]         head_q, body_q, tail_q;
	segst_t             new_q;
	logic               out_v_q;
	seg_t               out_q;

	segst_t             chain [SEGMENTS];
	segst_t             front;
	logic               shift, emit, cstart, cdone;
	logic [7:0]         len;
	logic [15:0]        chd;
	logic signed [CW-1:0] cox, coy;
	logic signed [16:0] dx, dy;

	// row of cells, front is cell 0, written-back segment enters at the tail
	genvar k;
	generate
		for (k = 0; k < SEGMENTS; k++) begin : g_cell
			if (k == SEGMENTS - 1) begin : g_tail
				flc_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(new_q), .q(chain[k]));
			end else begin : g_mid
				flc_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift),
					.d(chain[k+1]), .q(chain[k]));
			end
		end
	endgenerate

	assign front = chain[0];

	// length of the segment at the front
	always_comb begin
		if (idx_q == '0) len = head_q;
		else if (idx_q == SEG_LAST) len = tail_q;
		else len = body_q;
	end

	assign dx     = 17'(lx_q) - 17'(front.ex);
	assign dy     = 17'(ly_q) - 17'(front.ey);
	assign cstart = (st_q == S_LOAD) && op_q && moved_q;

	flc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart), .dx(dx), .dy(dy), .len(len),
		.done(cdone), .heading(chd), .ox(cox), .oy(coy)
	);

	// leader shifted to 24 fraction bits plus offset, then truncate toward zero
	function automatic logic signed [15:0] end_coord(input logic signed [15:0] l,
		input logic signed [CW-1:0] o);
		logic signed [SW-1:0] s, t;
		s = {{(SW-16-FRAC_SHIFT){l[15]}}, l, {FRAC_SHIFT{1'b0}}} + SW'(o);
		t = s + (s[SW-1] ? SW'({FRAC_SHIFT{1'b1}}) : SW'(0));
		return sat16(24'($signed(t[SW-1:FRAC_SHIFT])));
	endfunction

	assign emit      = (st_q == S_EMIT) && (!out_v_q || seg_ready);
	assign shift     = emit;
	assign tgt_ready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 8'd31;
			body_q <= 8'd18;
			tail_q <= 8'd23;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAD: head_q <= cfg_data;
				REG_BODY: body_q <= cfg_data;
				REG_TAIL: tail_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (seg_ready) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (tgt_valid) begin
						op_q    <= tgt.op;
						lx_q    <= tgt.target_x;
						ly_q    <= tgt.target_y;
						moved_q <= !tgt.op || tgt.target_x != front.sx
							|| tgt.target_y != front.sy;
						idx_q   <= '0;
						st_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (!op_q) begin
						// place: horizontal, heading zero
						new_q.sx <= lx_q;
						new_q.sy <= ly_q;
						new_q.ex <= sat16(24'(lx_q) + 24'(len));
						new_q.ey <= ly_q;
						new_q.hd <= '0;
						st_q     <= S_EMIT;
					end else if (!moved_q) begin
						new_q <= front;
						st_q  <= S_EMIT;
					end else begin
						st_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (cdone) begin
						new_q.hd <= chd;
						st_q     <= S_FIN;
					end
				end
				S_FIN: begin
					new_q.sx <= lx_q;
					new_q.sy <= ly_q;
					new_q.ex <= end_coord(lx_q, cox);
					new_q.ey <= end_coord(ly_q, coy);
					st_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						// this segment's end leads the next one
						lx_q <= new_q.ex;
						ly_q <= new_q.ey;
						if (idx_q == SEG_LAST) begin
							idx_q <= '0;
							st_q  <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= S_LOAD;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register, one segment beat
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.segment_index <= 3'(idx_q);
			out_q.start_x       <= new_q.sx;
			out_q.start_y       <= new_q.sy;
			out_q.end_x         <= new_q.ex;
			out_q.end_y         <= new_q.ey;
			out_q.heading       <= new_q.hd;
			out_q.moved         <= moved_q;
			out_q.last          <= (idx_q == SEG_LAST);
		end
	end

	assign seg_valid = out_v_q;
	assign seg       = out_q;

	`FLC_ASSERT_IMP(a_done_in_calc, cdone, st_q == S_CALC, "cordic finished outside calc")
	`FLC_ASSERT_IMP(a_idx_at_start, tgt_valid && tgt_ready, idx_q == '0, "chain not realigned")
	`FLC_ASSERT_NXT(a_last_to_idle, emit && idx_q == SEG_LAST, st_q == S_IDLE, "last beat left busy")
endmodule
`default_nettype wire
